// ===== design/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Widths, register indexes, pipeline layout, sine constants and shared types.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int IDX_W       = 11;
  localparam int COUNT_W     = 11;
  localparam int RADIUS_W    = 16;
  localparam int POS_W       = 17;
  localparam int NORM_W      = 16;
  localparam int TEX_W       = 17;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_FIELD_W = 3 * POS_W + 3 * NORM_W + 2 * TEX_W;
  localparam int OUT_DATA_W  = 136;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STACKS  = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 16'd256;
  localparam logic [COUNT_W-1:0]  SECTORS_RESET = 11'd36;
  localparam logic [COUNT_W-1:0]  STACKS_RESET  = 11'd18;
  localparam logic [COUNT_W-1:0]  MAX_DIVISIONS = 11'd1024;

  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_SHIFT       = 30 - NORMAL_FRAC_BITS;

  // Division lanes and sine lanes.
  localparam int LANES   = 4;
  localparam int LANE_PV = 0;
  localparam int LANE_PS = 1;
  localparam int LANE_TS = 2;
  localparam int LANE_TT = 3;
  localparam int SIN_CU  = 0;
  localparam int SIN_SU  = 1;
  localparam int SIN_CV  = 2;
  localparam int SIN_SV  = 3;

  // Pipeline layout.
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEPS  = 4;
  localparam int ITERS      = 5;
  localparam int SIN_STAGES = 3 + 2 * ITERS;
  localparam int SIN_FIRST  = 1 + DIV_STAGES;
  localparam int PROD_STAGE = SIN_FIRST + SIN_STAGES;
  localparam int OUT_STAGE  = PROD_STAGE + 1;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [61:0] HALF_Q30    = 62'h2000_0000;

  // Rounded-up reciprocal multipliers for the series divisors 110, 72, 42, 20, 6.
  localparam logic [64:0] MAGIC_110 = ((65'd1 << 39) + 65'd109) / 65'd110;
  localparam logic [64:0] MAGIC_72  = ((65'd1 << 39) + 65'd71) / 65'd72;
  localparam logic [64:0] MAGIC_42  = ((65'd1 << 38) + 65'd41) / 65'd42;
  localparam logic [64:0] MAGIC_20  = ((65'd1 << 37) + 65'd19) / 65'd20;
  localparam logic [64:0] MAGIC_6   = ((65'd1 << 35) + 65'd5) / 65'd6;
  localparam logic [32:0] RECIP_MAGIC [ITERS] = '{
    MAGIC_110[32:0], MAGIC_72[32:0], MAGIC_42[32:0], MAGIC_20[32:0], MAGIC_6[32:0]
  };
  localparam int RECIP_SHIFT [ITERS] = '{39, 39, 38, 37, 35};

  typedef struct packed {
    logic [COUNT_W-1:0] rem;
    logic [31:0]        num;
    logic [32:0]        quo;
  } div_state_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] x;
    logic [31:0] x2;
    logic [31:0] work;
  } sin_state_t;

  function automatic div_state_t div_step(input div_state_t st, input logic [COUNT_W-1:0] d);
    logic [COUNT_W:0] trial;
    logic             ge;
    div_state_t       res;
    trial   = {st.rem, st.num[31]};
    ge      = trial >= {1'b0, d};
    res.rem = ge ? COUNT_W'(trial - {1'b0, d}) : trial[COUNT_W-1:0];
    res.num = {st.num[30:0], 1'b0};
    res.quo = {st.quo[31:0], ge};
    return res;
  endfunction

endpackage

// ===== design/uv_sphere_vertex_generator_core.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator core
// Returns position, unit normal and texture coordinates of one grid vertex.
// ----------------------------------------------------------------------------
// Throughput is one vertex per cycle; the pipeline advances as a whole and
// holds only while the output register waits on m_tready.
// The depth is set by the 33-step restoring long division and the 13-stage sine.
// Reset clears all valid bits and loads the register defaults.
module uv_sphere_vertex_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // stack_index [10:0], sector_index [21:11]
  input  logic [uvs_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t
  output logic [uvs_pkg::OUT_DATA_W-1:0]   m_tdata,
  // index_error
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [uvs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import uvs_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic [COUNT_W-1:0]  sectors;
  logic [COUNT_W-1:0]  stacks;

  logic                adv;
  logic [OUT_STAGE:0]  valid;

  logic [IDX_W-1:0]    stack_index;
  logic [IDX_W-1:0]    sector_index;
  logic                in_error;
  logic [42:0]         num [LANES];
  logic [COUNT_W-1:0]  divisor [LANES];

  div_state_t          div_st      [DIV_STAGES+1][LANES];
  div_state_t          div_st_next [DIV_STAGES+1][LANES];
  logic [31:0]         phase [LANES];
  sin_state_t          sin_st      [SIN_STAGES][LANES];
  sin_state_t          sin_next    [SIN_STAGES][LANES];

  logic                err_p   [PROD_STAGE+1];
  logic [TEX_W-1:0]    tex_s_p [SIN_FIRST:PROD_STAGE];
  logic [TEX_W-1:0]    tex_t_p [SIN_FIRST:PROD_STAGE];

  logic [30:0]         d_mag      [3];
  logic [30:0]         d_mag_next [3];
  logic                d_neg      [3];
  logic                d_neg_next [3];

  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_DATA_W-1:0] out_data_next;
  logic                  out_err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= RADIUS_RESET;
      sectors <= SECTORS_RESET;
      stacks  <= STACKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIUS:  radius  <= cfg_data;
        CFG_SECTORS: sectors <= cfg_data[COUNT_W-1:0];
        CFG_STACKS:  stacks  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !valid[OUT_STAGE] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = valid[OUT_STAGE];
  assign m_tdata  = out_data;
  assign m_tuser  = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[OUT_STAGE-1:0], s_tvalid};
    end
  end

  assign stack_index  = s_tdata[IDX_W-1:0];
  assign sector_index = s_tdata[2*IDX_W-1:IDX_W];

  assign in_error = (sectors == '0) || (stacks == '0) ||
                    (sectors > MAX_DIVISIONS) || (stacks > MAX_DIVISIONS) ||
                    (stack_index > stacks) || (sector_index > sectors);

  assign num[LANE_PV] = {sector_index, 32'd0} + 43'(sectors >> 1);
  assign num[LANE_PS] = {1'b0, stack_index, 31'd0} + 43'(stacks >> 1);
  assign num[LANE_TS] = 43'({sector_index, 16'd0}) + 43'(sectors >> 1);
  assign num[LANE_TT] = 43'({stack_index, 16'd0}) + 43'(stacks >> 1);
  assign divisor[LANE_PV] = sectors;
  assign divisor[LANE_PS] = stacks;
  assign divisor[LANE_TS] = sectors;
  assign divisor[LANE_TT] = stacks;

  always_comb begin
    div_state_t         st;
    logic [COUNT_W-1:0] top;
    logic               ge;
    for (int l = 0; l < LANES; l++) begin
      top = num[l][42:32];
      ge  = top >= divisor[l];
      div_st_next[0][l].rem = ge ? (top - divisor[l]) : top;
      div_st_next[0][l].num = num[l][31:0];
      div_st_next[0][l].quo = {32'd0, ge};
      for (int s = 1; s <= DIV_STAGES; s++) begin
        st = div_st[s-1][l];
        for (int k = 0; k < DIV_STEPS; k++) begin
          st = div_step(st, divisor[l]);
        end
        div_st_next[s][l] = st;
      end
    end
  end

  assign phase[SIN_CU] = div_st[DIV_STAGES][LANE_PS].quo[31:0];
  assign phase[SIN_SU] = div_st[DIV_STAGES][LANE_PS].quo[31:0] + 32'h4000_0000;
  assign phase[SIN_CV] = div_st[DIV_STAGES][LANE_PV].quo[31:0] + 32'h4000_0000;
  assign phase[SIN_SV] = div_st[DIV_STAGES][LANE_PV].quo[31:0];

  always_comb begin
    logic [30:0] q;
    logic [61:0] prod;
    logic [62:0] prod2;
    logic [64:0] qm;
    logic [30:0] t;
    logic [30:0] s;
    sin_state_t  prev;
    for (int l = 0; l < LANES; l++) begin
      q    = phase[l][30] ? (ONE_Q30 - {1'b0, phase[l][29:0]}) : {1'b0, phase[l][29:0]};
      prod = q * HALF_PI_Q30;
      sin_next[0][l].neg  = phase[l][31];
      sin_next[0][l].x    = prod[60:30];
      sin_next[0][l].x2   = '0;
      sin_next[0][l].work = '0;

      prev = sin_st[0][l];
      prod = prev.x * prev.x;
      sin_next[1][l]    = prev;
      sin_next[1][l].x2 = prod[61:30];

      for (int k = 0; k < ITERS; k++) begin
        prev  = sin_st[1+2*k][l];
        t     = ONE_Q30 - prev.work[30:0];
        prod2 = prev.x2 * t;
        sin_next[2+2*k][l]      = prev;
        sin_next[2+2*k][l].work = prod2[61:30];

        prev = sin_st[2+2*k][l];
        qm   = prev.work * RECIP_MAGIC[k];
        sin_next[3+2*k][l]      = prev;
        sin_next[3+2*k][l].work = 32'(qm >> RECIP_SHIFT[k]);
      end

      prev = sin_st[SIN_STAGES-2][l];
      t    = ONE_Q30 - prev.work[30:0];
      prod = prev.x * t;
      s    = (prod[60:30] > ONE_Q30) ? ONE_Q30 : prod[60:30];
      sin_next[SIN_STAGES-1][l]      = prev;
      sin_next[SIN_STAGES-1][l].work = {1'b0, s};
    end
  end

  always_comb begin
    logic [61:0] pxy;
    pxy = sin_st[SIN_STAGES-1][SIN_CU].work[30:0] * sin_st[SIN_STAGES-1][SIN_CV].work[30:0]
          + HALF_Q30;
    d_mag_next[0] = pxy[60:30];
    pxy = sin_st[SIN_STAGES-1][SIN_CU].work[30:0] * sin_st[SIN_STAGES-1][SIN_SV].work[30:0]
          + HALF_Q30;
    d_mag_next[1] = pxy[60:30];
    d_mag_next[2] = sin_st[SIN_STAGES-1][SIN_SU].work[30:0];
    d_neg_next[0] = sin_st[SIN_STAGES-1][SIN_CU].neg ^ sin_st[SIN_STAGES-1][SIN_CV].neg;
    d_neg_next[1] = sin_st[SIN_STAGES-1][SIN_CU].neg ^ sin_st[SIN_STAGES-1][SIN_SV].neg;
    d_neg_next[2] = sin_st[SIN_STAGES-1][SIN_SU].neg;
  end

  always_comb begin
    logic [46:0]       pm;
    logic [30:0]       nm;
    logic [POS_W-1:0]  pmag;
    logic [NORM_W-1:0] nmag;
    logic [POS_W-1:0]  pos  [3];
    logic [NORM_W-1:0] norm [3];
    for (int k = 0; k < 3; k++) begin
      pm      = radius * d_mag[k] + 47'(HALF_Q30);
      pmag    = pm[46:30];
      nm      = d_mag[k] + 31'(1 << (NORM_SHIFT - 1));
      nmag    = NORM_W'(nm >> NORM_SHIFT);
      pos[k]  = d_neg[k] ? (~pmag + 1'b1) : pmag;
      norm[k] = d_neg[k] ? (~nmag + 1'b1) : nmag;
    end
    if (err_p[PROD_STAGE]) begin
      out_data_next = '0;
    end else begin
      out_data_next = {{OUT_PAD_W{1'b0}}, tex_t_p[PROD_STAGE], tex_s_p[PROD_STAGE],
                       norm[2], norm[1], norm[0], pos[2], pos[1], pos[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_st   <= div_st_next;
      sin_st   <= sin_next;
      err_p[0] <= in_error;
      for (int s = 1; s <= PROD_STAGE; s++) begin
        err_p[s] <= err_p[s-1];
      end
      tex_s_p[SIN_FIRST] <= div_st[DIV_STAGES][LANE_TS].quo[TEX_W-1:0];
      tex_t_p[SIN_FIRST] <= div_st[DIV_STAGES][LANE_TT].quo[TEX_W-1:0];
      for (int s = SIN_FIRST + 1; s <= PROD_STAGE; s++) begin
        tex_s_p[s] <= tex_s_p[s-1];
        tex_t_p[s] <= tex_t_p[s-1];
      end
      d_mag    <= d_mag_next;
      d_neg    <= d_neg_next;
      out_data <= out_data_next;
      out_err  <= err_p[PROD_STAGE];
    end
  end

endmodule

// ===== design/uvs_checker.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator checker
// Port-level assertions on the result stream and on s_tready, bound to the core.
// ----------------------------------------------------------------------------
module uvs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [uvs_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser
);
  import uvs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("index error result carries data");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request refused with an empty output");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (.*);
